FILE: design/ftfc_pkg.sv
// ----------------------------------------------------------------------------
// ftfc_pkg
// shared constants, types and controller codes of the five-tuple flow counter
// ----------------------------------------------------------------------------
package ftfc_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int COUNT_BITS    = 32;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_A_BITS    = 64;
  localparam int KEY_P_BITS    = 40;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // capture input beat, form key
    logic rd;        // issue read of scan slot
    logic step;      // advance scan slot
    logic hit_upd;   // write back incremented count of matched slot
    logic miss_upd;  // append or drop
    logic out_take;  // output beat accepted
  } cmd_t;

  typedef struct packed {
    logic scan_done;  // scan slot reached used count
    logic match;      // registered read data matches key
    logic out_valid;
  } stat_t;

endpackage

FILE: design/ftfc_ctrl.sv
// ----------------------------------------------------------------------------
// ftfc_ctrl
// sequencer for the linear table scan, each slot read and then compared in turn
// ----------------------------------------------------------------------------
module ftfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  input  ftfc_pkg::stat_t  stat,
  output ftfc_pkg::cmd_t   cmd
);

  ftfc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ftfc_pkg::ST_IDLE: begin
        if (in_valid) state_next = ftfc_pkg::ST_READ;
      end
      ftfc_pkg::ST_READ: begin
        if (stat.scan_done) state_next = ftfc_pkg::ST_OUT;
        else state_next = ftfc_pkg::ST_CMP;
      end
      ftfc_pkg::ST_CMP: begin
        if (stat.match) state_next = ftfc_pkg::ST_OUT;
        else state_next = ftfc_pkg::ST_READ;
      end
      ftfc_pkg::ST_OUT: begin
        if (out_ready) state_next = ftfc_pkg::ST_IDLE;
      end
      default: state_next = ftfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ftfc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ftfc_pkg::ST_READ: begin
        cmd.rd = !stat.scan_done;
        cmd.miss_upd = stat.scan_done;
      end
      ftfc_pkg::ST_CMP: begin
        cmd.hit_upd = stat.match;
        cmd.step = !stat.match;
      end
      ftfc_pkg::ST_OUT: begin
        cmd.out_take = out_ready;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/ftfc_datapath.sv
// ----------------------------------------------------------------------------
// ftfc_datapath
// key former, flow table memories, comparator, counters and result register
// ----------------------------------------------------------------------------
module ftfc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ftfc_pkg::cmd_t       cmd,
  output ftfc_pkg::stat_t      stat,
  input  logic                 is_ipv4,
  input  logic [7:0]           protocol,
  input  logic [31:0]          source_address,
  input  logic [31:0]          destination_address,
  input  logic [15:0]          source_port,
  input  logic [15:0]          destination_port,
  output logic [9:0]           entry_index,
  output logic [31:0]          entry_count,
  output logic                 inserted,
  output logic                 dropped,
  output logic [10:0]          flows_in_use,
  output logic [63:0]          total_packets,
  output logic [63:0]          tcp_packets,
  output logic [63:0]          udp_packets
);

  localparam int AW = ftfc_pkg::KEY_A_BITS;
  localparam int PW = ftfc_pkg::KEY_P_BITS;
  localparam int CW = ftfc_pkg::COUNT_BITS;
  localparam int IW = ftfc_pkg::IDX_BITS;
  localparam int UW = ftfc_pkg::USED_BITS;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  logic [AW-1:0] mem_a [ftfc_pkg::TABLE_ENTRIES];
  logic [PW-1:0] mem_p [ftfc_pkg::TABLE_ENTRIES];
  logic [CW-1:0] mem_c [ftfc_pkg::TABLE_ENTRIES];

  logic [AW-1:0] key_a, rd_a;
  logic [PW-1:0] key_p, rd_p;
  logic [CW-1:0] rd_c;
  logic [UW-1:0] scan, used;
  logic [63:0]   pkt_total, tcp_total, udp_total;
  logic          out_valid;

  logic          is_tcp, is_udp, wr_en;
  logic [IW-1:0] wr_idx;
  logic [AW-1:0] wr_a;
  logic [PW-1:0] wr_p;
  logic [CW-1:0] wr_c, cnt_inc;
  logic          full;

  assign is_tcp  = is_ipv4 && (protocol == ftfc_pkg::PROTO_TCP);
  assign is_udp  = is_ipv4 && (protocol == ftfc_pkg::PROTO_UDP);
  assign cnt_inc = (rd_c == COUNT_MAX) ? rd_c : rd_c + CW'(1);
  assign full    = (used == UW'(ftfc_pkg::TABLE_ENTRIES));

  assign stat.scan_done = (scan == used);
  assign stat.match     = (rd_a == key_a) && (rd_p == key_p);
  assign stat.out_valid = out_valid;

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = scan[IW-1:0];
    wr_a   = key_a;
    wr_p   = key_p;
    wr_c   = cnt_inc;
    if (cmd.hit_upd) begin
      wr_en = 1'b1;
    end else if (cmd.miss_upd && !full) begin
      wr_en  = 1'b1;
      wr_idx = used[IW-1:0];
      wr_c   = CW'(1);
    end
  end

  // memory ports: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_c[wr_idx] <= wr_c;
      if (cmd.miss_upd) begin
        mem_a[wr_idx] <= wr_a;
        mem_p[wr_idx] <= wr_p;
      end
    end
    if (cmd.rd) begin
      rd_a <= mem_a[scan[IW-1:0]];
      rd_p <= mem_p[scan[IW-1:0]];
      rd_c <= mem_c[scan[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      pkt_total <= '0;
      tcp_total <= '0;
      udp_total <= '0;
      out_valid <= 1'b0;
      scan      <= '0;
    end else begin
      if (cmd.load) begin
        pkt_total <= pkt_total + 64'd1;
        tcp_total <= tcp_total + {63'd0, is_tcp};
        udp_total <= udp_total + {63'd0, is_udp};
        scan      <= '0;
      end
      if (cmd.step) scan <= scan + UW'(1);
      if (cmd.miss_upd && !full) used <= used + UW'(1);
      if (cmd.hit_upd || cmd.miss_upd) out_valid <= 1'b1;
      else if (cmd.out_take) out_valid <= 1'b0;
    end
  end

  // key capture and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_a <= is_ipv4 ? {source_address, destination_address} : '0;
      if (!is_ipv4) key_p <= '0;
      else if (is_tcp || is_udp) key_p <= {source_port, destination_port, protocol};
      else key_p <= {32'd0, protocol};
    end
    if (cmd.hit_upd) begin
      entry_index <= 10'(scan);
      entry_count <= 32'(cnt_inc);
      inserted    <= 1'b0;
      dropped     <= 1'b0;
    end else if (cmd.miss_upd) begin
      entry_index <= full ? 10'd0 : 10'(used);
      entry_count <= full ? 32'd0 : 32'd1;
      inserted    <= !full;
      dropped     <= full;
    end
  end

  assign flows_in_use  = 11'(used);
  assign total_packets = pkt_total;
  assign tcp_packets   = tcp_total;
  assign udp_packets   = udp_total;

endmodule

FILE: design/five_tuple_flow_counter_top.sv
// ----------------------------------------------------------------------------
// five_tuple_flow_counter_top
// exact-match five-tuple flow table with per-flow and global packet counters
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one parsed packet header per beat.
//   output channel out_valid/out_ready carries one result per input beat.
//   an accepted beat forms its key, then the table is scanned linearly from
//   slot 0: each slot takes one registered memory read, then one compare.
//   the scan ends at the first matching slot on a hit, or once flows_in_use
//   slots have been compared on a miss; the single read port of the table
//   sets the slot-by-slot scan. one packet is in flight at a time; the next
//   beat can be taken in the cycle after the result beat leaves.
//   reset clears flow count and global counters; table contents are not
//   cleared, slots above the flow count are never read.
//   when the receiver stalls the result holds and no new beat is accepted.
// ----------------------------------------------------------------------------
module five_tuple_flow_counter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        is_ipv4,
  input  logic [7:0]  protocol,
  input  logic [31:0] source_address,
  input  logic [31:0] destination_address,
  input  logic [15:0] source_port,
  input  logic [15:0] destination_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  entry_index,
  output logic [31:0] entry_count,
  output logic        inserted,
  output logic        dropped,
  output logic [10:0] flows_in_use,
  output logic [63:0] total_packets,
  output logic [63:0] tcp_packets,
  output logic [63:0] udp_packets
);

  ftfc_pkg::cmd_t  cmd;
  ftfc_pkg::stat_t stat;

  ftfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ftfc_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .is_ipv4            (is_ipv4),
    .protocol           (protocol),
    .source_address     (source_address),
    .destination_address(destination_address),
    .source_port        (source_port),
    .destination_port   (destination_port),
    .entry_index        (entry_index),
    .entry_count        (entry_count),
    .inserted           (inserted),
    .dropped            (dropped),
    .flows_in_use       (flows_in_use),
    .total_packets      (total_packets),
    .tcp_packets        (tcp_packets),
    .udp_packets        (udp_packets)
  );

  assign out_valid = stat.out_valid;

`ifndef SYNTH
  // no input beat taken while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted with result pending");

  // a result never both inserts and drops
  a_ins_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(inserted && dropped))
    else $error("inserted and dropped together");

  // flow count only moves on an insert
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    (flows_in_use != $past(flows_in_use)) |-> (out_valid && inserted))
    else $error("flow count changed without insert");
`endif

endmodule

FILE: tb/flow_table_checker.sv
// ----------------------------------------------------------------------------
// flow_table_checker
// watches both channels of the five-tuple flow counter, keeps its own copy of
// the flow table and the global counters, and checks every result beat
// ----------------------------------------------------------------------------
module flow_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        is_ipv4,
  input  logic [7:0]  protocol,
  input  logic [31:0] source_address,
  input  logic [31:0] destination_address,
  input  logic [15:0] source_port,
  input  logic [15:0] destination_port,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [9:0]  entry_index,
  input  logic [31:0] entry_count,
  input  logic        inserted,
  input  logic        dropped,
  input  logic [10:0] flows_in_use,
  input  logic [63:0] total_packets,
  input  logic [63:0] tcp_packets,
  input  logic [63:0] udp_packets,
  output int          mismatches,
  output int          pending,
  output int          n_results,
  output int          n_inserts,
  output int          n_drops
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]  index;
    logic [31:0] count;
    logic        ins;
    logic        drop;
    logic [10:0] used;
    logic [63:0] total;
    logic [63:0] tcp;
    logic [63:0] udp;
  } flow_result_t;

  localparam logic [ftfc_pkg::COUNT_BITS-1:0] COUNT_SAT = '1;

  logic [ftfc_pkg::KEY_A_BITS-1:0] flow_addr_key [ftfc_pkg::TABLE_ENTRIES];
  logic [ftfc_pkg::KEY_P_BITS-1:0] flow_pp_key   [ftfc_pkg::TABLE_ENTRIES];
  logic [ftfc_pkg::COUNT_BITS-1:0] flow_tally    [ftfc_pkg::TABLE_ENTRIES];
  int                              flows_used;
  logic [63:0]                     pkt_total, tcp_total, udp_total;
  flow_result_t                    expected_results [$];

  assign pending = expected_results.size();

  function automatic flow_result_t lookup_flow();
    logic [ftfc_pkg::KEY_A_BITS-1:0] ka;
    logic [ftfc_pkg::KEY_P_BITS-1:0] kp;
    flow_result_t                    r;
    bit                              hit;
    ka  = '0;
    kp  = '0;
    r   = '0;
    hit = 1'b0;
    pkt_total++;
    if (is_ipv4) begin
      ka = {source_address, destination_address};
      if (protocol == ftfc_pkg::PROTO_TCP || protocol == ftfc_pkg::PROTO_UDP)
        kp = {source_port, destination_port, protocol};
      else
        kp = {32'd0, protocol};
      if (protocol == ftfc_pkg::PROTO_TCP) tcp_total++;
      if (protocol == ftfc_pkg::PROTO_UDP) udp_total++;
    end
    for (int i = 0; i < flows_used && !hit; i++) begin
      if (flow_addr_key[i] == ka && flow_pp_key[i] == kp) begin
        if (flow_tally[i] != COUNT_SAT) flow_tally[i]++;
        r.index = i[9:0];
        r.count = flow_tally[i][31:0];
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (flows_used < ftfc_pkg::TABLE_ENTRIES) begin
        flow_addr_key[flows_used] = ka;
        flow_pp_key[flows_used]   = kp;
        flow_tally[flows_used]    = 32'd1;
        r.index = flows_used[9:0];
        r.count = 32'd1;
        r.ins   = 1'b1;
        flows_used++;
      end else begin
        r.drop = 1'b1;
      end
    end
    r.used  = flows_used[10:0];
    r.total = pkt_total;
    r.tcp   = tcp_total;
    r.udp   = udp_total;
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    n_results  = 0;
    n_inserts  = 0;
    n_drops    = 0;
  end

  always @(posedge clk) begin
    flow_result_t e;
    if (rst) begin
      flows_used = 0;
      pkt_total  = '0;
      tcp_total  = '0;
      udp_total  = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("result beat with nothing expected", 64'd1, 64'd0);
        end else begin
          e = expected_results.pop_front();
          n_results++;
          if (e.ins)  n_inserts++;
          if (e.drop) n_drops++;
          if (entry_index !== e.index)
            report("entry_index", 64'(entry_index), 64'(e.index));
          if (entry_count !== e.count)
            report("entry_count", 64'(entry_count), 64'(e.count));
          if (inserted !== e.ins)
            report("inserted", 64'(inserted), 64'(e.ins));
          if (dropped !== e.drop)
            report("dropped", 64'(dropped), 64'(e.drop));
          if (flows_in_use !== e.used)
            report("flows_in_use", 64'(flows_in_use), 64'(e.used));
          if (total_packets !== e.total) report("total_packets", total_packets, e.total);
          if (tcp_packets !== e.tcp)     report("tcp_packets", tcp_packets, e.tcp);
          if (udp_packets !== e.udp)     report("udp_packets", udp_packets, e.udp);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(lookup_flow());
    end
  end

  final begin
    if (expected_results.size() != 0)
      $display("%0d expected results never arrived", expected_results.size());
  end
endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the five-tuple flow counter: directed headers, then random
// traffic over a pool of flows with random stalls and a long receiver hold
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 566;
  localparam int POOL_SIZE    = 48;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        is_ipv4 = 0;
  logic [7:0]  protocol = '0;
  logic [31:0] source_address = '0;
  logic [31:0] destination_address = '0;
  logic [15:0] source_port = '0;
  logic [15:0] destination_port = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [9:0]  entry_index;
  logic [31:0] entry_count;
  logic        inserted, dropped;
  logic [10:0] flows_in_use;
  logic [63:0] total_packets, tcp_packets, udp_packets;

  int mismatches, pending, n_results, n_inserts, n_drops;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left   = 0;

  typedef struct packed {
    logic        v4;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } header_t;

  header_t flow_pool [POOL_SIZE];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  five_tuple_flow_counter_top i_dut (.*);

  flow_table_checker i_checker (.*);

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // caller stands at a falling edge; returns at the falling edge after the beat
  task automatic send_header(input header_t h);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    is_ipv4             = h.v4;
    protocol            = h.proto;
    source_address      = h.src;
    destination_address = h.dst;
    source_port         = h.sport;
    destination_port    = h.dport;
    in_valid            = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic header_t random_header();
    header_t h;
    h.v4    = ($urandom_range(9) != 0);
    h.src   = $urandom;
    h.dst   = $urandom;
    h.sport = 16'($urandom);
    h.dport = 16'($urandom);
    case ($urandom_range(3))
      0: h.proto = ftfc_pkg::PROTO_TCP;
      1: h.proto = ftfc_pkg::PROTO_UDP;
      default: h.proto = 8'($urandom_range(255));
    endcase
    return h;
  endfunction

  task automatic run_random(input int count);
    header_t h;
    int      pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        h = flow_pool[$urandom_range(POOL_SIZE - 1)];
      end else if (pick < 90) begin
        // same flow key unless tcp/udp: ports only count for those
        h = flow_pool[$urandom_range(POOL_SIZE - 1)];
        h.sport = 16'($urandom);
        h.dport = 16'($urandom);
        if (!h.v4) begin
          h = random_header();
          h.v4 = 1'b0;
        end
      end else begin
        h = random_header();
      end
      send_header(h);
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    header_t directed [$];
    repeat (7) @(negedge clk);
    rst = 0;

    // non-ipv4 gives a zero key whatever the fields hold
    directed.push_back({1'b0, 8'hff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff});
    directed.push_back({1'b0, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0});
    directed.push_back({1'b1, ftfc_pkg::PROTO_TCP, 32'hffffffff, 32'hffffffff,
                        16'hffff, 16'hffff});
    directed.push_back({1'b1, ftfc_pkg::PROTO_TCP, 32'hffffffff, 32'hffffffff,
                        16'hffff, 16'hffff});
    directed.push_back({1'b1, ftfc_pkg::PROTO_UDP, 32'h0, 32'h0, 16'hffff, 16'h0});
    directed.push_back({1'b1, ftfc_pkg::PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'hffff});
    directed.push_back({1'b1, ftfc_pkg::PROTO_TCP, 32'h0, 32'h0, 16'hffff, 16'h0});
    // other protocols ignore ports
    directed.push_back({1'b1, 8'd1, 32'h0a000001, 32'h0a000002, 16'h1234, 16'h5678});
    directed.push_back({1'b1, 8'd1, 32'h0a000001, 32'h0a000002, 16'hbeef, 16'h0001});
    directed.push_back({1'b1, 8'hff, 32'h80000000, 32'h00000001, 16'h8000, 16'h0001});
    // ipv4 protocol zero with zero addresses collides with the non-ipv4 key
    directed.push_back({1'b1, 8'h00, 32'h0, 32'h0, 16'h4321, 16'h8765});
    directed.push_back({1'b0, ftfc_pkg::PROTO_TCP, 32'h12345678, 32'h9abcdef0,
                        16'h1, 16'h2});
    directed.push_back({1'b1, ftfc_pkg::PROTO_UDP, 32'hffffffff, 32'hffffffff,
                        16'hffff, 16'hffff});
    directed.push_back({1'b1, ftfc_pkg::PROTO_TCP, 32'hffffffff, 32'hffffffff,
                        16'hffff, 16'hffff});
    foreach (directed[i]) send_header(directed[i]);

    for (int i = 0; i < POOL_SIZE; i++) flow_pool[i] = random_header();

    tx_idle_pct = 11;
    rx_idle_pct = 50;
    run_random(RANDOM_ITEMS / 3);
    tx_idle_pct = 50;
    rx_idle_pct = 11;
    run_random(RANDOM_ITEMS / 3);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left   = 400;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    in_valid = 0;

    wait_drained();
    repeat (50) @(negedge clk);
    $display("covered %0d results: %0d new flows, %0d dropped on a full table",
             n_results, n_inserts, n_drops);
    $display("table ended with %0d flows, %0d tcp and %0d udp packets",
             flows_in_use, tcp_packets, udp_packets);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout with %0d results pending", pending);
    $display("status: fail");
    $finish;
  end
endmodule
